>>> rtl/core/rmr_pkg.sv
// Shared types and constants of the rational multiply and reduce core.
package rmr_pkg;

  // Fixed widths of the result fields.
  localparam int unsigned OUT_NUM_W = 63;
  localparam int unsigned OUT_DEN_W = 62;

  // Largest positive numerator that the result field may carry.
  localparam logic [OUT_NUM_W-1:0] POS_LIMIT = {1'b0, {(OUT_NUM_W-1){1'b1}}};

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_GCD,
    ST_DIV_NUM,
    ST_NEXT_DIV,
    ST_DIV_DEN,
    ST_FINISH
  } rmr_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;           // capture an accepted input item
    logic mul_num;        // multiply the numerator magnitudes
    logic mul_den;        // multiply the denominators
    logic gcd_step;       // one binary GCD iteration
    logic div_start_num;  // form the divisor and start dividing the numerator
    logic div_start_den;  // keep the numerator quotient, start on the denominator
    logic div_step;       // one restoring division step
    logic out_load;       // move the finished result into the output register
  } rmr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero;      // the numerator product is zero
    logic gcd_done;  // both GCD operands are equal
    logic div_last;  // the current division step is the final one
    logic out_free;  // the output register can take a result this cycle
  } rmr_sts_t;

endpackage

>>> rtl/core/rmr_if.sv
// Valid/ready channel interfaces for the input fractions and the reduced product.
interface rmr_in_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] numerator_a;
  logic        [VALUE_WIDTH-2:0] denominator_a;
  logic signed [VALUE_WIDTH-1:0] numerator_b;
  logic        [VALUE_WIDTH-2:0] denominator_b;

  modport source (
    output valid, numerator_a, denominator_a, numerator_b, denominator_b,
    input  ready
  );
  modport sink (
    input  valid, numerator_a, denominator_a, numerator_b, denominator_b,
    output ready
  );
endinterface

interface rmr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rmr_pkg::OUT_NUM_W-1:0] product_numerator;
  logic        [rmr_pkg::OUT_DEN_W-1:0] product_denominator;

  modport source (
    output valid, product_numerator, product_denominator,
    input  ready
  );
  modport sink (
    input  valid, product_numerator, product_denominator,
    output ready
  );
endinterface

>>> rtl/core/rmr_ctrl.sv
// Sequencing state machine of the rational multiply and reduce core.
module rmr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rmr_pkg::rmr_sts_t sts_i,
  output rmr_pkg::rmr_cmd_t cmd_o
);
  import rmr_pkg::*;

  rmr_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL_NUM;
        end
      end
      ST_MUL_NUM: begin
        cmd_o.mul_num = 1'b1;
        state_d       = sts_i.zero ? ST_FINISH : ST_MUL_DEN;
      end
      ST_MUL_DEN: begin
        cmd_o.mul_den = 1'b1;
        state_d       = ST_GCD;
      end
      ST_GCD: begin
        if (sts_i.gcd_done) begin
          cmd_o.div_start_num = 1'b1;
          state_d             = ST_DIV_NUM;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      ST_DIV_NUM: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_NEXT_DIV;
        end
      end
      ST_NEXT_DIV: begin
        cmd_o.div_start_den = 1'b1;
        state_d             = ST_DIV_DEN;
      end
      ST_DIV_DEN: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/rmr_datapath.sv
// Multiplier, binary GCD unit, restoring divider and output register of the core.
module rmr_datapath #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rmr_pkg::rmr_cmd_t                     cmd_i,
  output rmr_pkg::rmr_sts_t                     sts_o,
  input  logic signed [VALUE_WIDTH-1:0]         numerator_a_i,
  input  logic        [VALUE_WIDTH-2:0]         denominator_a_i,
  input  logic signed [VALUE_WIDTH-1:0]         numerator_b_i,
  input  logic        [VALUE_WIDTH-2:0]         denominator_b_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic signed [rmr_pkg::OUT_NUM_W-1:0]  product_numerator_o,
  output logic        [rmr_pkg::OUT_DEN_W-1:0]  product_denominator_o
);
  import rmr_pkg::*;

  // Products need two bits fewer than twice the input width, plus one.
  localparam int unsigned PW    = 2 * VALUE_WIDTH - 1;
  localparam int unsigned CNT_W = $clog2(PW);

  // Captured operands.
  logic [VALUE_WIDTH-1:0] mag_a_q, mag_b_q;
  logic [VALUE_WIDTH-1:0] den_a_q, den_b_q;
  logic                   neg_q, zero_q;

  // Products, GCD operands and divider state.
  logic [PW-1:0]    num_q, den_q;
  logic [PW-1:0]    x_q, y_q;
  logic [CNT_W-1:0] k_q;
  logic [PW-1:0]    div_q, rem_q, quo_q, num_res_q;
  logic [CNT_W-1:0] cnt_q;

  // Output register.
  logic                        out_valid_q;
  logic signed [OUT_NUM_W-1:0] out_num_q;
  logic        [OUT_DEN_W-1:0] out_den_q;

  // Sign and magnitude split of the inputs; a zero denominator counts as one.
  logic [VALUE_WIDTH-1:0] mag_a_in, mag_b_in, den_a_in, den_b_in;
  assign mag_a_in = numerator_a_i[VALUE_WIDTH-1] ? -numerator_a_i : numerator_a_i;
  assign mag_b_in = numerator_b_i[VALUE_WIDTH-1] ? -numerator_b_i : numerator_b_i;
  assign den_a_in = (denominator_a_i == '0) ? VALUE_WIDTH'(1) : {1'b0, denominator_a_i};
  assign den_b_in = (denominator_b_i == '0) ? VALUE_WIDTH'(1) : {1'b0, denominator_b_i};

  // One shared multiplier for both products.
  logic [VALUE_WIDTH-1:0]   mul_a, mul_b;
  logic [2*VALUE_WIDTH-1:0] mul_p;
  assign mul_a = cmd_i.mul_num ? mag_a_q : den_a_q;
  assign mul_b = cmd_i.mul_num ? mag_b_q : den_b_q;
  assign mul_p = mul_a * mul_b;

  // Binary GCD step: strip common and single factors of two, else subtract the smaller from the larger and halve.
  logic [PW-1:0]    x_d, y_d, x_minus_y, y_minus_x;
  logic [CNT_W-1:0] k_d;
  assign x_minus_y = x_q - y_q;
  assign y_minus_x = y_q - x_q;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    k_d = k_q;
    if (!x_q[0] && !y_q[0]) begin
      x_d = x_q >> 1;
      y_d = y_q >> 1;
      k_d = k_q + CNT_W'(1);
    end else if (!x_q[0]) begin
      x_d = x_q >> 1;
    end else if (!y_q[0]) begin
      y_d = y_q >> 1;
    end else if (x_q > y_q) begin
      x_d = x_minus_y >> 1;
    end else begin
      y_d = y_minus_x >> 1;
    end
  end

  // Restoring division step: one quotient bit a cycle.
  logic [PW:0]   partial;
  logic          ge;
  logic [PW:0]   partial_sub;
  assign partial     = {rem_q, quo_q[PW-1]};
  assign ge          = partial >= {1'b0, div_q};
  assign partial_sub = partial - {1'b0, div_q};

  // Signed numerator of the result with positive saturation.
  logic [OUT_NUM_W-1:0] num_mag_ext, num_signed;
  assign num_mag_ext = OUT_NUM_W'(num_res_q);
  always_comb begin
    if (neg_q) begin
      num_signed = -num_mag_ext;
    end else if (num_mag_ext > POS_LIMIT) begin
      num_signed = POS_LIMIT;
    end else begin
      num_signed = num_mag_ext;
    end
  end

  // Operand capture and products.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_a_q <= mag_a_in;
      mag_b_q <= mag_b_in;
      den_a_q <= den_a_in;
      den_b_q <= den_b_in;
      neg_q   <= numerator_a_i[VALUE_WIDTH-1] ^ numerator_b_i[VALUE_WIDTH-1];
      zero_q  <= (mag_a_in == '0) || (mag_b_in == '0);
    end
    if (cmd_i.mul_num) begin
      num_q <= mul_p[PW-1:0];
      x_q   <= mul_p[PW-1:0];
      k_q   <= '0;
    end else if (cmd_i.mul_den) begin
      den_q <= mul_p[PW-1:0];
      y_q   <= mul_p[PW-1:0];
    end else if (cmd_i.gcd_step) begin
      x_q <= x_d;
      y_q <= y_d;
      k_q <= k_d;
    end
  end

  // Divider registers, shared by the numerator and the denominator.
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start_num) begin
      div_q <= x_q << k_q;
      quo_q <= num_q;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_start_den) begin
      num_res_q <= quo_q;
      quo_q     <= den_q;
      rem_q     <= '0;
      cnt_q     <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? partial_sub[PW-1:0] : partial[PW-1:0];
      quo_q <= {quo_q[PW-2:0], ge};
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload; a zero product reads as 0/1.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (zero_q) begin
        out_num_q <= '0;
        out_den_q <= OUT_DEN_W'(1);
      end else begin
        out_num_q <= num_signed;
        out_den_q <= OUT_DEN_W'(quo_q);
      end
    end
  end

  assign sts_o.zero     = zero_q;
  assign sts_o.gcd_done = (x_q == y_q);
  assign sts_o.div_last = (cnt_q == CNT_W'(PW - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o           = out_valid_q;
  assign product_numerator_o   = out_num_q;
  assign product_denominator_o = out_den_q;

  // The GCD loop never steps once its operands have met.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.gcd_step |-> (x_q != y_q))
    else $error("GCD step issued with equal operands");

  // The partial remainder always stays below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < div_q))
    else $error("Division remainder not below divisor");

  // A zero product is delivered as 0/1.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && zero_q) |=>
      (out_valid_q && out_num_q == '0 && out_den_q == OUT_DEN_W'(1)))
    else $error("Zero product not delivered as 0/1");

endmodule

>>> rtl/core/rational_multiply_reduce_core.sv
// Multiplies two fractions and reduces the product to lowest terms; one
// transfer in gives one transfer out. An item runs twice through the shared
// multiplier, then a binary GCD loop of one step a cycle (at most
// 2*(2*VALUE_WIDTH-1) steps, set by the operand bit lengths) and two
// restoring divisions on one shared divider; a zero numerator skips
// the denominator product, the GCD loop and the divisions. The core takes
// one item at a time, but a finished result waits in the output register
// while the next item is accepted.
module rational_multiply_reduce_core #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rmr_in_if.sink     in_i,
  rmr_out_if.source  out_o
);
  import rmr_pkg::*;

  rmr_cmd_t cmd;
  rmr_sts_t sts;
  logic     in_ready;

  // Sequencer.
  rmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Arithmetic and output register.
  rmr_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .numerator_a_i         (in_i.numerator_a),
    .denominator_a_i       (in_i.denominator_a),
    .numerator_b_i         (in_i.numerator_b),
    .denominator_b_i       (in_i.denominator_b),
    .out_ready_i           (out_o.ready),
    .out_valid_o           (out_o.valid),
    .product_numerator_o   (out_o.product_numerator),
    .product_denominator_o (out_o.product_denominator)
  );

  assign in_i.ready = in_ready;

endmodule
